// ===== design/stlex_pkg.sv =====
// ----------------------------------------------------------------------------
// stlex_pkg: shared types and constants for the source text lexer
// Token kind codes, keyword spellings, byte classes and the control group
// that the scanner hands to the result queue.
// ----------------------------------------------------------------------------
package stlex_pkg;

    typedef logic [5:0] kind_t;

    // Keywords take kinds 0..13 in the order of the table below
    localparam int KW_COUNT = 14;

    localparam kind_t KIND_NUMBER   = 6'd14;
    localparam kind_t KIND_ASSIGN   = 6'd15;
    localparam kind_t KIND_EQ       = 6'd16;
    localparam kind_t KIND_NE       = 6'd17;
    localparam kind_t KIND_LT       = 6'd18;
    localparam kind_t KIND_LE       = 6'd19;
    localparam kind_t KIND_GT       = 6'd20;
    localparam kind_t KIND_GE       = 6'd21;
    localparam kind_t KIND_DOT      = 6'd22;
    localparam kind_t KIND_IDENT    = 6'd23;
    localparam kind_t KIND_STRING   = 6'd24;
    localparam kind_t KIND_PLUS     = 6'd25;
    localparam kind_t KIND_MINUS    = 6'd26;
    localparam kind_t KIND_STAR     = 6'd27;
    localparam kind_t KIND_SLASH    = 6'd28;
    localparam kind_t KIND_LPAREN   = 6'd29;
    localparam kind_t KIND_RPAREN   = 6'd30;
    localparam kind_t KIND_SEMI     = 6'd31;
    localparam kind_t KIND_COMMA    = 6'd32;
    localparam kind_t KIND_COLON    = 6'd33;
    localparam kind_t KIND_MISMATCH = 6'd34;
    localparam kind_t KIND_UNTERM   = 6'd35;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_LESS   = 8'h3C;
    localparam logic [7:0] CH_GREAT  = 8'h3E;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;
    localparam logic [7:0] CH_DOT    = 8'h2E;

    localparam int FIFO_DEPTH = 4;

    // Spellings left-aligned, NUL padded, first byte in the top byte
    localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
        {"program", 8'h00}, {"const", 24'h0}, {"var", 40'h0}, {"begin", 24'h0},
        {"end", 40'h0}, {"if", 48'h0}, {"then", 32'h0}, {"else", 32'h0},
        {"Write", 24'h0}, {"Read", 32'h0}, {"double", 16'h0}, {"integer", 8'h00},
        {"mod", 40'h0}, {"div", 40'h0}
    };

    localparam logic [2:0] KW_LEN [KW_COUNT] = '{
        3'd7, 3'd5, 3'd3, 3'd5, 3'd3, 3'd2, 3'd4, 3'd4, 3'd5, 3'd4, 3'd6, 3'd7, 3'd3, 3'd3
    };

    // Push request from the scanner: second only ever comes with first
    typedef struct packed {
        logic first;
        logic second;
    } fifo_push_t;

    function automatic logic [7:0] kw_byte(input logic [3:0] k, input logic [2:0] idx);
        logic [63:0] word;
        word = KW_TEXT[k];
        return word[63 - 8*idx -: 8];
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    // Kind of a byte that forms a token on its own
    function automatic kind_t byte_kind(input logic [7:0] c);
        kind_t k;
        unique case (c)
            CH_EQUAL: k = KIND_EQ;
            CH_DOT:   k = KIND_DOT;
            8'h2B:    k = KIND_PLUS;
            8'h2D:    k = KIND_MINUS;
            8'h2A:    k = KIND_STAR;
            8'h2F:    k = KIND_SLASH;
            8'h28:    k = KIND_LPAREN;
            8'h29:    k = KIND_RPAREN;
            8'h3B:    k = KIND_SEMI;
            8'h2C:    k = KIND_COMMA;
            default:  k = KIND_MISMATCH;
        endcase
        return k;
    endfunction

endpackage

// ===== design/stlex_token_fifo.sv =====
// ----------------------------------------------------------------------------
// stlex_token_fifo: result queue
// Four-entry queue that takes up to two tokens per cycle and hands out one.
// ----------------------------------------------------------------------------
module stlex_token_fifo
    import stlex_pkg::*;
#(
    parameter int DATA_WIDTH = 55
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  fifo_push_t            push,
    input  logic [DATA_WIDTH-1:0] push_data0,
    input  logic [DATA_WIDTH-1:0] push_data1,
    output logic                  room_for_two,
    output logic                  pop_valid,
    input  logic                  pop_ready,
    output logic [DATA_WIDTH-1:0] pop_data
);

    localparam int PTR_WIDTH = $clog2(FIFO_DEPTH);
    localparam int CNT_WIDTH = $clog2(FIFO_DEPTH + 1);

    logic [DATA_WIDTH-1:0] entry_reg [FIFO_DEPTH];
    logic [PTR_WIDTH-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_WIDTH-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_WIDTH-1:0]  count_reg, count_next;
    logic                  pop;

    assign pop_valid    = count_reg != '0;
    assign pop_data     = entry_reg[rd_ptr_reg];
    assign pop          = pop_valid && pop_ready;
    // Pop is not counted here; keeps ready off the output handshake path
    assign room_for_two = count_reg <= CNT_WIDTH'(FIFO_DEPTH - 2);

    always_comb begin
        wr_ptr_next = wr_ptr_reg + PTR_WIDTH'(push.first) + PTR_WIDTH'(push.second);
        rd_ptr_next = rd_ptr_reg + PTR_WIDTH'(pop);
        count_next  = count_reg + CNT_WIDTH'(push.first) + CNT_WIDTH'(push.second)
                    - CNT_WIDTH'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.first) begin
            entry_reg[wr_ptr_reg] <= push_data0;
        end
        if (push.second) begin
            entry_reg[wr_ptr_reg + PTR_WIDTH'(1)] <= push_data1;
        end
    end

endmodule

// ===== design/source_text_lexer.sv =====
// ----------------------------------------------------------------------------
// source_text_lexer: streaming lexer
// Takes source bytes and emits tokens as kind, start position and length.
// ----------------------------------------------------------------------------
//  channel | direction | payload
//  s_      | in        | character, end_marker
//  m_      | out       | kind, start_pos, length, last_of_run
//
//  One byte per cycle: the scan state updates in the cycle of the transfer and
//  the tokens it ends land in a four-entry result queue, which m_ reads.
//  A byte that yields two tokens fills two queue slots; the input sustains one
//  byte per cycle as long as at least two slots are free.
//  Reset is synchronous, active low; no clearing pass, ready right after.
//  A stall on m_ backs up the queue and drops s_ready once fewer than two
//  slots remain free.
// ----------------------------------------------------------------------------
module source_text_lexer
    import stlex_pkg::*;
#(
    parameter int POSITION_WIDTH = 32,
    parameter int LENGTH_WIDTH   = 16
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [7:0]                s_character,
    input  logic                      s_end_marker,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [5:0]                m_kind,
    output logic [POSITION_WIDTH-1:0] m_start_pos,
    output logic [LENGTH_WIDTH-1:0]   m_length,
    output logic                      m_last_of_run
);

    localparam int TOKEN_WIDTH = 6 + POSITION_WIDTH + LENGTH_WIDTH + 1;

    typedef enum logic [8:0] {
        MODE_IDLE    = 9'b000000001,
        MODE_IDENT   = 9'b000000010,
        MODE_INT     = 9'b000000100,
        MODE_FRAC    = 9'b000001000,
        MODE_STRING  = 9'b000010000,
        MODE_COLON   = 9'b000100000,
        MODE_LESS    = 9'b001000000,
        MODE_GREATER = 9'b010000000,
        MODE_BANG    = 9'b100000000
    } scan_mode_t;

    scan_mode_t                mode_reg, mode_next;
    logic [POSITION_WIDTH-1:0] start_reg, start_next;
    logic [POSITION_WIDTH-1:0] pos_reg, pos_next;
    logic [LENGTH_WIDTH-1:0]   len_reg, len_next;
    logic [KW_COUNT-1:0]       kw_reg, kw_next;

    logic                      transfer;
    logic [7:0]                c;
    logic                      taken;
    logic [LENGTH_WIDTH-1:0]   len_grown;
    logic [KW_COUNT-1:0]       kw_narrowed, kw_first, kw_hit;
    kind_t                     ident_kind, pending_kind, pair_kind;
    logic                      pending_valid;

    logic                      tok_a_valid, tok_b_valid;
    kind_t                     tok_a_kind;
    logic [LENGTH_WIDTH-1:0]   tok_a_len;
    logic [TOKEN_WIDTH-1:0]    tok_a_data, tok_b_data;
    fifo_push_t                push;
    logic [TOKEN_WIDTH-1:0]    push_data0, push_data1, pop_data;

    assign transfer  = s_valid && s_ready;
    assign c         = s_character;
    assign len_grown = (len_reg == '1) ? len_reg : len_reg + LENGTH_WIDTH'(1);

    // Keyword candidate tracking, one compare per keyword
    always_comb begin
        for (int k = 0; k < KW_COUNT; k++) begin
            kw_narrowed[k] = kw_reg[k] && (len_reg < LENGTH_WIDTH'(8))
                           && (kw_byte(4'(k), len_reg[2:0]) == c);
            kw_first[k]    = kw_byte(4'(k), 3'd0) == c;
            kw_hit[k]      = kw_reg[k] && (len_reg == LENGTH_WIDTH'(KW_LEN[k]));
        end
    end

    // Later keywords win, as in the table order
    always_comb begin
        ident_kind = KIND_IDENT;
        for (int k = 0; k < KW_COUNT; k++) begin
            if (kw_hit[k]) begin
                ident_kind = 6'(k);
            end
        end
    end

    always_comb begin
        pending_valid = 1'b1;
        pending_kind  = KIND_MISMATCH;
        pair_kind     = KIND_NE;
        unique case (mode_reg)
            MODE_IDENT:          pending_kind = ident_kind;
            MODE_INT, MODE_FRAC: pending_kind = KIND_NUMBER;
            MODE_STRING:         pending_kind = KIND_UNTERM;
            MODE_COLON:  begin
                pending_kind = KIND_COLON;
                pair_kind    = KIND_ASSIGN;
            end
            MODE_LESS: begin
                pending_kind = KIND_LT;
                pair_kind    = KIND_LE;
            end
            MODE_GREATER: begin
                pending_kind = KIND_GT;
                pair_kind    = KIND_GE;
            end
            MODE_BANG:           pending_kind = KIND_MISMATCH;
            default:             pending_valid = 1'b0;
        endcase
    end

    always_comb begin
        mode_next   = mode_reg;
        start_next  = start_reg;
        pos_next    = pos_reg;
        len_next    = len_reg;
        kw_next     = kw_reg;
        taken       = 1'b0;
        tok_a_valid = 1'b0;
        tok_a_kind  = pending_kind;
        tok_a_len   = len_reg;
        tok_b_valid = 1'b0;

        // Try to extend the pending token
        if (!s_end_marker) begin
            unique case (mode_reg)
                MODE_IDENT: begin
                    if (is_letter(c) || is_digit(c)) begin
                        kw_next  = kw_narrowed;
                        len_next = len_grown;
                        taken    = 1'b1;
                    end
                end
                MODE_INT: begin
                    if (c == CH_DOT) begin
                        mode_next = MODE_FRAC;
                        len_next  = len_grown;
                        taken     = 1'b1;
                    end else if (is_digit(c)) begin
                        len_next  = len_grown;
                        taken     = 1'b1;
                    end
                end
                MODE_FRAC: begin
                    if (is_digit(c)) begin
                        len_next = len_grown;
                        taken    = 1'b1;
                    end
                end
                MODE_STRING: begin
                    taken = 1'b1;
                    if (c == CH_QUOTE) begin
                        tok_a_valid = 1'b1;
                        tok_a_kind  = KIND_STRING;
                        tok_a_len   = len_grown;
                        mode_next   = MODE_IDLE;
                        len_next    = '0;
                    end else begin
                        len_next    = len_grown;
                    end
                end
                MODE_COLON, MODE_LESS, MODE_GREATER, MODE_BANG: begin
                    if (c == CH_EQUAL) begin
                        taken       = 1'b1;
                        tok_a_valid = 1'b1;
                        tok_a_kind  = pair_kind;
                        tok_a_len   = LENGTH_WIDTH'(2);
                        mode_next   = MODE_IDLE;
                        len_next    = '0;
                    end
                end
                default: ;
            endcase
        end

        // Otherwise flush it and start over on this byte
        if (s_end_marker || !taken) begin
            tok_a_valid = pending_valid;
            tok_a_kind  = pending_kind;
            tok_a_len   = len_reg;
            mode_next   = MODE_IDLE;
            len_next    = '0;
            kw_next     = '1;
            if (s_end_marker) begin
                pos_next = '0;
            end else begin
                start_next = pos_reg;
                if (c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR) begin
                    len_next = '0;
                end else if (is_letter(c)) begin
                    mode_next = MODE_IDENT;
                    kw_next   = kw_first;
                    len_next  = LENGTH_WIDTH'(1);
                end else if (is_digit(c)) begin
                    mode_next = MODE_INT;
                    len_next  = LENGTH_WIDTH'(1);
                end else if (c == CH_QUOTE) begin
                    mode_next = MODE_STRING;
                    len_next  = LENGTH_WIDTH'(1);
                end else if (c == CH_COLON) begin
                    mode_next = MODE_COLON;
                    len_next  = LENGTH_WIDTH'(1);
                end else if (c == CH_LESS) begin
                    mode_next = MODE_LESS;
                    len_next  = LENGTH_WIDTH'(1);
                end else if (c == CH_GREAT) begin
                    mode_next = MODE_GREATER;
                    len_next  = LENGTH_WIDTH'(1);
                end else if (c == CH_BANG) begin
                    mode_next = MODE_BANG;
                    len_next  = LENGTH_WIDTH'(1);
                end else begin
                    tok_b_valid = 1'b1;
                end
            end
        end

        if (!s_end_marker) begin
            pos_next = pos_reg + POSITION_WIDTH'(1);
        end
    end

    // Pack and compact: the only token of a byte always goes to slot 0
    always_comb begin
        tok_a_data  = {tok_a_kind, start_reg, tok_a_len, !tok_b_valid};
        tok_b_data  = {byte_kind(c), pos_reg, LENGTH_WIDTH'(1), 1'b1};
        push.first  = transfer && (tok_a_valid || tok_b_valid);
        push.second = transfer && tok_a_valid && tok_b_valid;
        push_data0  = tok_a_valid ? tok_a_data : tok_b_data;
        push_data1  = tok_b_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_IDLE;
            start_reg <= '0;
            pos_reg   <= '0;
            len_reg   <= '0;
            kw_reg    <= '1;
        end else if (transfer) begin
            mode_reg  <= mode_next;
            start_reg <= start_next;
            pos_reg   <= pos_next;
            len_reg   <= len_next;
            kw_reg    <= kw_next;
        end
    end

    stlex_token_fifo #(
        .DATA_WIDTH(TOKEN_WIDTH)
    ) u_result_fifo (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .push        (push),
        .push_data0  (push_data0),
        .push_data1  (push_data1),
        .room_for_two(s_ready),
        .pop_valid   (m_valid),
        .pop_ready   (m_ready),
        .pop_data    (pop_data)
    );

    assign {m_kind, m_start_pos, m_length, m_last_of_run} = pop_data;

endmodule

// ===== design/stlex_checker.sv =====
// ----------------------------------------------------------------------------
// stlex_checker: port-level checks for the source text lexer
// Watches both channels and the kinds and lengths the result channel carries.
// ----------------------------------------------------------------------------
module stlex_checker
    import stlex_pkg::*;
#(
    parameter int POSITION_WIDTH = 32,
    parameter int LENGTH_WIDTH   = 16
) (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_valid,
    input logic                      s_ready,
    input logic [7:0]                s_character,
    input logic                      s_end_marker,
    input logic                      m_valid,
    input logic                      m_ready,
    input logic [5:0]                m_kind,
    input logic [POSITION_WIDTH-1:0] m_start_pos,
    input logic [LENGTH_WIDTH-1:0]   m_length,
    input logic                      m_last_of_run
);

    // A waiting source byte holds until its transfer
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_character) && $stable(s_end_marker))
        else $error("source byte changed while waiting");

    // A stalled result holds until its transfer
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_kind) && $stable(m_start_pos)
                                && $stable(m_length) && $stable(m_last_of_run))
        else $error("result changed while stalled");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_length != '0)
        else $error("token of zero length");

    // Two-byte operators always span exactly two bytes
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_kind == KIND_ASSIGN || m_kind == KIND_NE || m_kind == KIND_LE
                    || m_kind == KIND_GE) |-> m_length == LENGTH_WIDTH'(2))
        else $error("two-byte operator with wrong length");

    // Single-byte punctuation and comparison tokens
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_kind == KIND_EQ || m_kind == KIND_DOT || m_kind == KIND_LT
                    || m_kind == KIND_GT || m_kind == KIND_COLON
                    || (m_kind >= KIND_PLUS && m_kind <= KIND_COMMA))
        |-> m_length == LENGTH_WIDTH'(1))
        else $error("one-byte token with wrong length");

endmodule

bind source_text_lexer stlex_checker #(
    .POSITION_WIDTH(POSITION_WIDTH),
    .LENGTH_WIDTH  (LENGTH_WIDTH)
) u_stlex_checker (.*);

// ===== tb/sv/source_text_lexer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// source_text_lexer_tb: self-checking bench for the streaming lexer
// Directed and random source text goes in as bursts with random gaps while
// the token side stalls on its own pattern. A scanner model in the bench
// predicts every token, and each token transfer is checked in order.
// Two long tokens at the end run the length well past the keyword table.
// ----------------------------------------------------------------------------
module source_text_lexer_tb;
    import stlex_pkg::*;

    localparam int POS_W        = 32;
    localparam int LEN_W        = 16;
    localparam int RANDOM_ITEMS = 1220;
    localparam int LONG_TOKEN   = 60;
    localparam int LONG_HOLD    = 300;
    localparam int HOLD_AFTER   = 400;
    localparam int IDLE_LIMIT   = 5000;
    localparam int DRAIN_CYCLES = 32;
    localparam logic [LEN_W-1:0] LEN_MAX = '1;

    typedef enum logic [3:0] {
        SC_IDLE, SC_IDENT, SC_INT, SC_FRAC, SC_STRING,
        SC_COLON, SC_LESS, SC_GREATER, SC_BANG
    } scan_mode_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       eom;
    } src_byte_t;

    typedef struct packed {
        kind_t            kind;
        logic [POS_W-1:0] start;
        logic [LEN_W-1:0] len;
        logic             last;
    } token_t;

    logic             aclk          = 1'b0;
    logic             aresetn       = 1'b0;
    logic             s_valid       = 1'b0;
    logic             s_ready;
    logic [7:0]       s_character   = '0;
    logic             s_end_marker  = 1'b0;
    logic             m_valid;
    logic             m_ready       = 1'b0;
    logic [5:0]       m_kind;
    logic [POS_W-1:0] m_start_pos;
    logic [LEN_W-1:0] m_length;
    logic             m_last_of_run;

    string kw_names [KW_COUNT] = '{
        "program", "const", "var", "begin", "end", "if", "then",
        "else", "Write", "Read", "double", "integer", "mod", "div"
    };
    string op_list [18] = '{
        ":=", "=", "!=", "<", "<=", ">", ">=", ".", "+", "-", "*", "/",
        "(", ")", ";", ",", ":", "!"
    };
    string alpha_pool = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ";
    string digit_pool = "0123456789";

    src_byte_t source_q [$];
    token_t    token_q [$];
    int        err_count = 0;
    int        bytes_in  = 0;

    // scanner model state
    scan_mode_t       lx_mode;
    logic [POS_W-1:0] lx_start;
    logic [POS_W-1:0] lx_pos;
    logic [LEN_W-1:0] lx_len;
    logic [13:0]      lx_kw;
    token_t           step_tok [2];
    int               step_n;

    source_text_lexer u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_character   (s_character),
        .s_end_marker  (s_end_marker),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_kind        (m_kind),
        .m_start_pos   (m_start_pos),
        .m_length      (m_length),
        .m_last_of_run (m_last_of_run)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ---------------- scanner model ----------------
    function automatic bit is_alpha(logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic bit is_num(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic void note_token(kind_t kind, logic [POS_W-1:0] start,
                                       logic [LEN_W-1:0] len);
        step_tok[step_n] = '{kind, start, len, 1'b0};
        step_n++;
    endfunction

    function automatic void lexer_reset();
        lx_mode  = SC_IDLE;
        lx_start = '0;
        lx_pos   = '0;
        lx_len   = '0;
        lx_kw    = '1;
    endfunction

    // drop keywords whose next letter differs from c
    function automatic void narrow_keywords(logic [7:0] c);
        logic [13:0] keep;
        keep = '0;
        if (lx_len < 8) begin
            for (int k = 0; k < KW_COUNT; k++)
                if (lx_kw[k] && kw_names[k][int'(lx_len)] == c)
                    keep[k] = 1'b1;
        end
        lx_kw = keep;
    endfunction

    function automatic void grow_token();
        if (lx_len != LEN_MAX)
            lx_len++;
    endfunction

    function automatic void close_token();
        kind_t kind;
        bit    any;
        kind = KIND_IDENT;
        any  = 1'b1;
        case (lx_mode)
            SC_IDENT: begin
                for (int k = 0; k < KW_COUNT; k++)
                    if (lx_kw[k] && kw_names[k].len() == lx_len)
                        kind = kind_t'(k);
            end
            SC_INT, SC_FRAC: kind = KIND_NUMBER;
            SC_STRING:       kind = KIND_UNTERM;
            SC_COLON:        kind = KIND_COLON;
            SC_LESS:         kind = KIND_LT;
            SC_GREATER:      kind = KIND_GT;
            SC_BANG:         kind = KIND_MISMATCH;
            default:         any = 1'b0;
        endcase
        if (any)
            note_token(kind, lx_start, lx_len);
        lx_mode = SC_IDLE;
        lx_len  = '0;
        lx_kw   = '1;
    endfunction

    function automatic void open_token(logic [7:0] c);
        kind_t kind;
        lx_start = lx_pos;
        lx_len   = LEN_W'(1);
        if (c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR) begin
            lx_len = '0;
        end else if (is_alpha(c)) begin
            lx_mode = SC_IDENT;
            lx_kw   = '1;
            lx_len  = '0;
            narrow_keywords(c);
            lx_len  = LEN_W'(1);
        end else if (is_num(c)) begin
            lx_mode = SC_INT;
        end else if (c == CH_QUOTE) begin
            lx_mode = SC_STRING;
        end else if (c == CH_COLON) begin
            lx_mode = SC_COLON;
        end else if (c == CH_LESS) begin
            lx_mode = SC_LESS;
        end else if (c == CH_GREAT) begin
            lx_mode = SC_GREATER;
        end else if (c == CH_BANG) begin
            lx_mode = SC_BANG;
        end else begin
            case (c)
                CH_EQUAL: kind = KIND_EQ;
                CH_DOT:   kind = KIND_DOT;
                "+":      kind = KIND_PLUS;
                "-":      kind = KIND_MINUS;
                "*":      kind = KIND_STAR;
                "/":      kind = KIND_SLASH;
                "(":      kind = KIND_LPAREN;
                ")":      kind = KIND_RPAREN;
                ";":      kind = KIND_SEMI;
                ",":      kind = KIND_COMMA;
                default:  kind = KIND_MISMATCH;
            endcase
            note_token(kind, lx_start, LEN_W'(1));
            lx_len = '0;
        end
    endfunction

    // returns 1 when c joins the pending token
    function automatic bit extend_token(logic [7:0] c);
        kind_t kind;
        case (lx_mode)
            SC_IDENT: begin
                if (is_alpha(c) || is_num(c)) begin
                    narrow_keywords(c);
                    grow_token();
                    return 1'b1;
                end
            end
            SC_INT: begin
                if (c == CH_DOT) begin
                    lx_mode = SC_FRAC;
                    grow_token();
                    return 1'b1;
                end else if (is_num(c)) begin
                    grow_token();
                    return 1'b1;
                end
            end
            SC_FRAC: begin
                if (is_num(c)) begin
                    grow_token();
                    return 1'b1;
                end
            end
            SC_STRING: begin
                grow_token();
                if (c == CH_QUOTE) begin
                    note_token(KIND_STRING, lx_start, lx_len);
                    lx_mode = SC_IDLE;
                    lx_len  = '0;
                end
                return 1'b1;
            end
            SC_COLON, SC_LESS, SC_GREATER, SC_BANG: begin
                if (c == CH_EQUAL) begin
                    case (lx_mode)
                        SC_COLON:   kind = KIND_ASSIGN;
                        SC_LESS:    kind = KIND_LE;
                        SC_GREATER: kind = KIND_GE;
                        default:    kind = KIND_NE;
                    endcase
                    note_token(kind, lx_start, LEN_W'(2));
                    lx_mode = SC_IDLE;
                    lx_len  = '0;
                    return 1'b1;
                end
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    task automatic scan_byte(logic [7:0] c, logic eom);
        token_t t;
        step_n = 0;
        if (eom) begin
            close_token();
            lx_pos = '0;
        end else begin
            if (!extend_token(c)) begin
                close_token();
                open_token(c);
            end
            lx_pos = lx_pos + 1'b1;
        end
        for (int i = 0; i < step_n; i++) begin
            t      = step_tok[i];
            t.last = (i == step_n - 1);
            token_q.insert(token_q.size(), t);
        end
    endtask

    // ---------------- source text ----------------
    function automatic void push_char(logic [7:0] c);
        src_byte_t b;
        b.ch  = c;
        b.eom = 1'b0;
        source_q.insert(source_q.size(), b);
    endfunction

    function automatic void push_text(string s);
        for (int i = 0; i < s.len(); i++)
            push_char(s[i]);
    endfunction

    function automatic void push_end();
        src_byte_t b;
        b.ch  = 8'($urandom_range(0, 255));
        b.eom = 1'b1;
        source_q.insert(source_q.size(), b);
    endfunction

    function automatic logic [7:0] rand_alnum(bit letter_only);
        string pool;
        pool = letter_only ? alpha_pool : {alpha_pool, digit_pool};
        return pool[$urandom_range(0, pool.len() - 1)];
    endfunction

    function automatic logic [7:0] rand_digit();
        return digit_pool[$urandom_range(0, 9)];
    endfunction

    // any byte but the closing quote
    function automatic logic [7:0] string_byte();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        return (c == CH_QUOTE) ? CH_LF : c;
    endfunction

    function automatic void push_random_token();
        int    pick;
        string word;
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
            push_text(kw_names[$urandom_range(0, KW_COUNT - 1)]);
        end else if (pick < 20) begin
            // near misses: keyword cut short or running on
            word = kw_names[$urandom_range(0, KW_COUNT - 1)];
            if ($urandom_range(0, 1)) begin
                push_text(word.substr(0, word.len() - 2));
            end else begin
                push_text(word);
                repeat ($urandom_range(1, 2)) push_char(rand_alnum(1'b0));
            end
        end else if (pick < 32) begin
            push_char(rand_alnum(1'b1));
            repeat ($urandom_range(0, 7)) push_char(rand_alnum(1'b0));
        end else if (pick < 42) begin
            repeat ($urandom_range(1, 4)) push_char(rand_digit());
            if ($urandom_range(0, 1)) begin
                push_char(CH_DOT);
                repeat ($urandom_range(0, 3)) push_char(rand_digit());
            end
        end else if (pick < 50) begin
            push_char(CH_QUOTE);
            repeat ($urandom_range(0, 6)) push_char(string_byte());
            if ($urandom_range(0, 7) != 0)
                push_char(CH_QUOTE);
            else
                push_end();
        end else if (pick < 68) begin
            push_text(op_list[$urandom_range(0, 17)]);
        end else if (pick < 72) begin
            push_char(8'($urandom_range(0, 255)));
        end else if (pick < 77) begin
            push_end();
        end
        // separator, or none so that tokens run into each other
        if ($urandom_range(0, 9) > 3) begin
            repeat ($urandom_range(1, 2)) begin
                case ($urandom_range(0, 3))
                    0: push_char(CH_SPACE);
                    1: push_char(CH_TAB);
                    2: push_char(CH_LF);
                    default: push_char(CH_CR);
                endcase
            end
        end
    endfunction

    // ---------------- sender ----------------
    src_byte_t next_byte;
    int        gap_left   = 0;
    int        burst_left = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid      <= 1'b0;
            s_character  <= '0;
            s_end_marker <= 1'b0;
            gap_left     = 0;
            burst_left   = 0;
        end else if (!s_valid || s_ready) begin
            if (gap_left > 0 || source_q.size() == 0) begin
                if (gap_left > 0)
                    gap_left--;
                s_valid <= 1'b0;
            end else begin
                next_byte = source_q.pop_front();
                s_valid      <= 1'b1;
                s_character  <= next_byte.ch;
                s_end_marker <= next_byte.eom;
                if (burst_left > 0) begin
                    burst_left--;
                end else if ($urandom_range(0, 3) == 0) begin
                    burst_left = $urandom_range(40, 120);
                    gap_left   = 0;
                end else begin
                    burst_left = $urandom_range(1, 12);
                    gap_left   = $urandom_range(0, 6);
                end
            end
        end
    end

    // ---------------- receiver ----------------
    int hold_left = 0;
    int seg_left  = 0;
    int stall_pct = 0;
    bit held_long = 1'b0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready   <= 1'b0;
            hold_left = 0;
            seg_left  = 0;
            stall_pct = 0;
            held_long = 1'b0;
        end else begin
            if (seg_left == 0) begin
                seg_left = $urandom_range(16, 96);
                case ($urandom_range(0, 3))
                    0: stall_pct = 0;
                    1: stall_pct = 25;
                    2: stall_pct = 50;
                    default: stall_pct = 85;
                endcase
            end else begin
                seg_left--;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (!held_long && bytes_in >= HOLD_AFTER) begin
                // long hold-off: result queue fills and s_ready must drop
                held_long = 1'b1;
                hold_left = LONG_HOLD;
                m_ready   <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // ---------------- monitor ----------------
    function automatic void compare_field(string field, logic [31:0] want,
                                          logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch expected %0d actual %0d", $time, field, want, got);
            err_count++;
        end
    endfunction

    token_t want_tok;

    always @(posedge aclk) begin
        if (!aresetn) begin
            lexer_reset();
        end else begin
            if (s_valid && s_ready) begin
                scan_byte(s_character, s_end_marker);
                bytes_in++;
            end
            if (m_valid && m_ready) begin
                if (token_q.size() == 0) begin
                    $display("%0t: unexpected token kind %0d start %0d length %0d",
                             $time, m_kind, m_start_pos, m_length);
                    err_count++;
                end else begin
                    want_tok = token_q.pop_front();
                    compare_field("kind", 32'(want_tok.kind), 32'(m_kind));
                    compare_field("start_pos", want_tok.start, m_start_pos);
                    compare_field("length", 32'(want_tok.len), 32'(m_length));
                    compare_field("last_of_run", 32'(want_tok.last), 32'(m_last_of_run));
                end
            end
        end
    end

    // ---------------- watchdog ----------------
    int idle_cycles = 0;

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // ---------------- stimulus and end of run ----------------
    initial begin
        int directed_len;
        // two-byte operators, number with trailing dot, lone bang,
        // carriage return, extreme bytes, unterminated string, empty flush
        push_text("if:=12.<=x>=!=!y");
        push_char(CH_CR);
        push_char(8'h00);
        push_char(8'hFF);
        push_text("\"ab");
        push_end();
        push_end();
        directed_len = source_q.size();

        while (source_q.size() < directed_len + RANDOM_ITEMS)
            push_random_token();
        push_end();

        // long identifier, then long string with newlines
        push_char(rand_alnum(1'b1));
        repeat (LONG_TOKEN - 1) push_char(rand_alnum(1'b0));
        push_end();
        push_char(CH_QUOTE);
        repeat (LONG_TOKEN) push_char(string_byte());
        push_char(CH_QUOTE);
        push_end();

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        while (source_q.size() != 0 || s_valid)
            @(posedge aclk);
        while (token_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (err_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
design/stlex_pkg.sv
design/stlex_token_fifo.sv
design/source_text_lexer.sv
design/stlex_checker.sv
tb/sv/source_text_lexer_tb.sv
